FILE: hdl/fps_pkg.sv
// Package for the flight phase sequencer: phase codes, register indexes,
// hold times and output levels. No dependencies.
`default_nettype none

package fps_pkg;

  // Mission phases.
  localparam logic [2:0] PH_ASCENT  = 3'd0;
  localparam logic [2:0] PH_DESCENT = 3'd1;
  localparam logic [2:0] PH_LANDING = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_STEER   = 3'd4;
  localparam logic [2:0] PH_FINAL   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_ASCENT_ALT   = 3'd0;
  localparam logic [2:0] REG_DESCENT_SPD  = 3'd1;
  localparam logic [2:0] REG_LANDING_BAND = 3'd2;
  localparam logic [2:0] REG_GOAL_LON     = 3'd3;
  localparam logic [2:0] REG_GOAL_TOL     = 3'd4;
  localparam logic [2:0] REG_STEER_GAIN   = 3'd5;
  localparam logic [2:0] REG_GOAL_HDG     = 3'd6;
  localparam logic [2:0] REG_START_PHASE  = 3'd7;

  localparam int unsigned CFG_W = 32;

  // Hold times in milliseconds.
  localparam logic [31:0] HOLD_LONG_MS  = 32'd10000;
  localparam logic [31:0] HOLD_SHORT_MS = 32'd3000;

  localparam logic [7:0] DRIVE_MAX     = 8'd255;
  localparam logic [7:0] SERVO_RELEASE = 8'd90;

  // Heading wrap limits in tenths of a degree.
  localparam logic signed [12:0] HALF_TURN = 13'sd1800;
  localparam logic signed [12:0] FULL_TURN = 13'sd3600;

  // The steering duty is product / 160 = (product >> 5) / 5. The quotient by 5
  // uses a reciprocal that is exact below 16384; at or above QUOT_SAT the duty
  // saturates anyway.
  localparam logic [13:0] QUOT_SAT   = 14'd1280;
  localparam logic [24:0] RECIP_FIVE = 25'd13108;

endpackage

`default_nettype wire

FILE: hdl/flight_phase_sequencer.sv
// Flight phase sequencer top level: input register, phase update logic and
// result register. Depends on fps_pkg.
`default_nettype none
//
// Usage:
//   Samples enter on the in_ channel (valid/ready) and one result item leaves
//   on the out_ channel (valid/ready) for every sample, in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
//   write them only while no item is in flight. Writing the
//   start phase register loads the phase and disarms the hold timer.
//   A sample accepted sits in the input register; its result is presented
//   from the result register once the item moves on, which a stall can delay.
//   Throughput: one item per cycle while out_ready holds. The sample-only
//   terms (threshold compares, longitude gap, heading error times gain) are
//   formed on the way into the input register; the phase update, hold timer
//   and duty scaling sit between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both stages, sets phase 0, disarms
//   the hold timer, zeroes motor and servo levels and loads the register
//   defaults.
//   When the receiver stalls the result holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
//
module flight_phase_sequencer
  import fps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         in_now_ms,
  input  wire logic [24:0]         in_altitude,
  input  wire logic [17:0]         in_vertical_speed,
  input  wire logic [11:0]         in_heading,
  input  wire logic [31:0]         in_longitude,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_phase,
  output logic [7:0]               out_left_drive,
  output logic [7:0]               out_right_drive,
  output logic [7:0]               out_servo_angle,
  output logic [11:0]              out_heading_error,

  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic signed [24:0] ascent_alt_r;
  logic signed [17:0] descent_spd_r;
  logic        [16:0] landing_band_r;
  logic signed [31:0] goal_lon_r;
  logic        [31:0] goal_tol_r;
  logic        [7:0]  steer_gain_r;
  logic        [11:0] goal_hdg_r;

  // Input register.
  logic               s1_valid_r;
  logic        [31:0] s1_now_r;
  logic               s1_alt_ok_r;
  logic               s1_desc_ok_r;
  logic               s1_land_ok_r;
  logic               s1_arrive_r;
  logic signed [11:0] s1_err_r;
  logic        [18:0] s1_prod_r;

  // Block state and result register.
  logic               out_valid_r;
  logic        [2:0]  phase_r, phase_nxt;
  logic               armed_r, armed_nxt;
  logic        [31:0] hold_start_r, hold_start_nxt;
  logic        [7:0]  left_r, left_nxt;
  logic        [7:0]  right_r, right_nxt;
  logic        [7:0]  servo_r, servo_nxt;
  logic signed [11:0] herr_r, herr_nxt;

  logic               move;
  logic               in_fire;
  logic               start_wr;

  // Sample-only terms.
  logic               alt_ok;
  logic               desc_ok;
  logic               land_ok;
  logic signed [18:0] vs_ext;
  logic signed [18:0] band_pos;
  logic signed [18:0] band_neg;
  logic signed [32:0] lon_diff;
  logic        [32:0] lon_gap;
  logic               arrive;
  logic signed [12:0] err_raw;
  logic signed [12:0] err_wrap;
  logic        [10:0] err_mag;
  logic        [18:0] prod;

  // Update terms.
  logic        [31:0] elapsed;
  logic        [31:0] hold_limit;
  logic               cond;
  logic               fire;
  logic        [13:0] quot;
  logic        [24:0] recip;
  logic        [7:0]  duty;

  assign move      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || move;
  assign in_fire   = in_valid && in_ready;
  assign start_wr  = cfg_we && (cfg_index == REG_START_PHASE);

  assign out_valid         = out_valid_r;
  assign out_phase         = phase_r;
  assign out_left_drive    = left_r;
  assign out_right_drive   = right_r;
  assign out_servo_angle   = servo_r;
  assign out_heading_error = herr_r;

  // ---------------- Sample terms, formed on the way in ----------------
  always_comb begin
    alt_ok   = $signed(in_altitude) > ascent_alt_r;
    desc_ok  = $signed(in_vertical_speed) < descent_spd_r;
    vs_ext   = 19'($signed(in_vertical_speed));
    band_pos = $signed({2'b00, landing_band_r});
    band_neg = -band_pos;
    land_ok  = (vs_ext < band_pos) && (vs_ext > band_neg);

    lon_diff = $signed({in_longitude[31], in_longitude}) -
               $signed({goal_lon_r[31], goal_lon_r});
    lon_gap  = lon_diff[32] ? 33'(-lon_diff) : 33'(lon_diff);
    arrive   = lon_gap < {1'b0, goal_tol_r};

    err_raw = $signed({1'b0, goal_hdg_r}) - $signed({1'b0, in_heading});
    if (err_raw > HALF_TURN) begin
      err_wrap = err_raw - FULL_TURN;
    end else if (err_raw < -HALF_TURN) begin
      err_wrap = err_raw + FULL_TURN;
    end else begin
      err_wrap = err_raw;
    end
    err_mag = err_wrap[12] ? 11'(-err_wrap) : err_wrap[10:0];
    prod    = {8'b0, err_mag} * {11'b0, steer_gain_r};
  end

  // ---------------- Phase update ----------------
  always_comb begin
    phase_nxt      = phase_r;
    armed_nxt      = armed_r;
    hold_start_nxt = hold_start_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    servo_nxt      = servo_r;
    herr_nxt       = herr_r;

    elapsed    = s1_now_r - hold_start_r;
    hold_limit = (phase_r == PH_RELEASE) ? HOLD_SHORT_MS : HOLD_LONG_MS;
    fire       = armed_r && (elapsed > hold_limit);

    unique case (phase_r)
      PH_ASCENT:  cond = s1_alt_ok_r;
      PH_DESCENT: cond = s1_desc_ok_r;
      PH_LANDING: cond = s1_land_ok_r;
      PH_RELEASE: cond = 1'b1;
      default:    cond = 1'b0;
    endcase

    quot  = s1_prod_r[18:5];
    recip = {14'b0, quot[10:0]} * RECIP_FIVE;
    duty  = (quot >= QUOT_SAT) ? DRIVE_MAX : recip[23:16];

    if (start_wr) begin
      phase_nxt = (cfg_wdata[2:0] > PH_FINAL) ? PH_FINAL : cfg_wdata[2:0];
      armed_nxt = 1'b0;
    end else if (move) begin
      if (phase_r == PH_STEER) begin
        if (s1_arrive_r) begin
          phase_nxt = PH_FINAL;
          armed_nxt = 1'b0;
        end
      end else if (phase_r != PH_FINAL) begin
        if (!cond) begin
          armed_nxt = 1'b0;
        end else if (!armed_r) begin
          armed_nxt      = 1'b1;
          hold_start_nxt = s1_now_r;
        end else if (fire) begin
          phase_nxt = phase_r + 3'd1;
          armed_nxt = 1'b0;
        end
      end

      // Actions belong to the phase reached after this item.
      herr_nxt = '0;
      if (phase_nxt == PH_RELEASE) begin
        left_nxt  = DRIVE_MAX;
        right_nxt = DRIVE_MAX;
        servo_nxt = SERVO_RELEASE;
      end else if (phase_nxt == PH_STEER) begin
        herr_nxt = s1_err_r;
        if (s1_err_r > 0) begin
          left_nxt  = duty;
          right_nxt = '0;
        end else if (s1_err_r < 0) begin
          left_nxt  = '0;
          right_nxt = duty;
        end else begin
          left_nxt  = '0;
          right_nxt = '0;
        end
      end
    end
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascent_alt_r   <= 25'sd10000;
      descent_spd_r  <= '0;
      landing_band_r <= 17'd50;
      goal_lon_r     <= '0;
      goal_tol_r     <= 32'd100000000;
      steer_gain_r   <= 8'd24;
      goal_hdg_r     <= 12'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ASCENT_ALT:   ascent_alt_r   <= $signed(cfg_wdata[24:0]);
        REG_DESCENT_SPD:  descent_spd_r  <= $signed(cfg_wdata[17:0]);
        REG_LANDING_BAND: landing_band_r <= cfg_wdata[16:0];
        REG_GOAL_LON:     goal_lon_r     <= $signed(cfg_wdata[31:0]);
        REG_GOAL_TOL:     goal_tol_r     <= cfg_wdata[31:0];
        REG_STEER_GAIN:   steer_gain_r   <= cfg_wdata[7:0];
        REG_GOAL_HDG:     goal_hdg_r     <= cfg_wdata[11:0];
        REG_START_PHASE:  ;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r     <= in_now_ms;
      s1_alt_ok_r  <= alt_ok;
      s1_desc_ok_r <= desc_ok;
      s1_land_ok_r <= land_ok;
      s1_arrive_r  <= arrive;
      s1_err_r     <= err_wrap[11:0];
      s1_prod_r    <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      phase_r      <= PH_ASCENT;
      armed_r      <= 1'b0;
      hold_start_r <= '0;
      left_r       <= '0;
      right_r      <= '0;
      servo_r      <= '0;
      herr_r       <= '0;
    end else begin
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      phase_r      <= phase_nxt;
      armed_r      <= armed_nxt;
      hold_start_r <= hold_start_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      servo_r      <= servo_nxt;
      herr_r       <= herr_nxt;
    end
  end

  // ---------------- Assertions ----------------
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_FINAL)
    else $error("phase beyond the final phase");

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    move && !start_wr |=> (phase_r == $past(phase_r)) ||
                          (phase_r == $past(phase_r) + 3'd1))
    else $error("phase moved by more than one step");

  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !move && !start_wr |=> $stable(phase_r))
    else $error("phase changed without an item or a start write");

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (herr_r != 0) |-> phase_r == PH_STEER)
    else $error("heading error reported outside steering");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (phase_r == PH_STEER) |-> (left_r == 0) || (right_r == 0))
    else $error("both motors driven while steering");

endmodule

`default_nettype wire
